// ===== rtl/nau_pkg.sv =====
// shared types and constants for the activation unit
// no dependencies; used by neural_activation_unit
`timescale 1ns / 1ps
`default_nettype none

package nau_pkg;

    // fixed field widths of the two channels
    localparam int SAMPLE_WIDTH = 16;
    localparam int VALUE_WIDTH  = 32;

    // function codes
    localparam logic [3:0] FN_SIGMOID   = 4'd0;
    localparam logic [3:0] FN_SIGMOID_D = 4'd1;
    localparam logic [3:0] FN_TANH      = 4'd2;
    localparam logic [3:0] FN_TANH_D    = 4'd3;
    localparam logic [3:0] FN_RELU      = 4'd4;
    localparam logic [3:0] FN_RELU_D    = 4'd5;
    localparam logic [3:0] FN_SQUARE    = 4'd6;
    localparam logic [3:0] FN_SQRT      = 4'd7;
    localparam logic [3:0] FN_SUM       = 4'd8;

    // exponential evaluation: fraction bits, series length, integer cutoff
    localparam int EXP_FRAC     = 30;
    localparam int SERIES_TERMS = 20;
    localparam int EXP_MAX_INT  = 40;

    // leak factor after reset, unsigned Q0.16
    localparam logic [15:0] LEAK_RESET = 16'd655;

    typedef struct packed {
        logic [3:0]                     func;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last_element;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          error_flag;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/neural_activation_unit.sv =====
// activation function unit: sequencer around one shared multiplier and divider
// depends on nau_pkg for channel structs, function codes and constants
`timescale 1ns / 1ps
`default_nettype none

// One element at a time: req_stall is high from the accepting edge until the
// result is parked in the output register, and it stays high while that result
// waits behind a stalled rsp. A sum element that is not last, and an element
// with an unknown function code, give no transaction on rsp. A last sum
// element, relu of a non-negative sample, relu derivative and square root of a
// negative sample go from decode straight to the result; relu of a negative
// sample and square take one product, and square root runs its bit-pair steps.
// Sigmoid, tanh and their derivatives run a 20-term series on one shared 32x32
// multiplier and a 1-bit-per-cycle restoring divider, then multiply by e^-1
// once per integer unit of the argument (at most 8 for sigmoid and 16 for tanh
// with 16-bit samples), then do a rounding division. The first such element
// with an argument of 1.0 or more after reset runs the series a second time
// to build the e^-1 constant, which is then kept.
module neural_activation_unit #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire nau_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output nau_pkg::rsp_t      rsp,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [15:0]   cfg_data
);

    localparam int SW     = nau_pkg::SAMPLE_WIDTH;
    localparam int VW     = nau_pkg::VALUE_WIDTH;
    localparam int EF     = nau_pkg::EXP_FRAC;
    localparam int E_W    = EF + 1;
    localparam int A_W    = SW + 1;
    localparam int ONE_W  = FRAC_BITS + 1;
    localparam int DIVD_W = 33 + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);
    localparam int SQ_W   = ((SW + FRAC_BITS + 1) / 2) * 2;
    localparam int I_W    = $clog2(nau_pkg::EXP_MAX_INT + 1);

    localparam logic [E_W-1:0]   QONE     = E_W'(1) << EF;
    localparam logic [ONE_W-1:0] ONE      = ONE_W'(1) << FRAC_BITS;
    localparam logic [VW-1:0]    ONE_V    = VW'(1) << FRAC_BITS;
    localparam logic [VW-1:0]    VMAX     = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0]    VMIN     = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_DECODE   = 16'h0002,
        S_SER_MUL  = 16'h0004,
        S_SER_LOAD = 16'h0008,
        S_SER_DIV  = 16'h0010,
        S_SER_ACC  = 16'h0020,
        S_SER_END  = 16'h0040,
        S_POW      = 16'h0080,
        S_POW_UPD  = 16'h0100,
        S_FIN_LOAD = 16'h0200,
        S_FIN_DIV  = 16'h0400,
        S_FIN_RES  = 16'h0800,
        S_DRV_MUL  = 16'h1000,
        S_DRV_OUT  = 16'h2000,
        S_SQRT     = 16'h4000,
        S_RESULT   = 16'h8000
    } state_t;

    state_t                  state_reg, state_next;
    logic [3:0]              func_reg, func_next;
    logic signed [SW-1:0]    x_reg, x_next;
    logic                    last_reg, last_next;
    logic                    neg_reg, neg_next;
    logic [SW-1:0]           absx_reg, absx_next;
    logic [A_W-1:0]          a_reg, a_next;
    logic [E_W-1:0]          f_reg, f_next;
    logic [E_W-1:0]          term_reg, term_next;
    logic signed [32:0]      acc_reg, acc_next;
    logic [4:0]              k_reg, k_next;
    logic [E_W-1:0]          einv_reg, einv_next;
    logic                    einv_valid_reg, einv_valid_next;
    logic                    einv_mode_reg, einv_mode_next;
    logic [E_W-1:0]          e_reg, e_next;
    logic [I_W-1:0]          i_reg, i_next;
    logic [63:0]             prod_reg, prod_next;
    logic [DIVD_W-1:0]       quo_reg, quo_next;
    logic [31:0]             rem_reg, rem_next;
    logic [31:0]             dvs_reg, dvs_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ONE_W-1:0]        t_reg, t_next;
    logic [SQ_W-1:0]         sqv_reg, sqv_next;
    logic [SQ_W-1:0]         sqr_reg, sqr_next;
    logic [SQ_W-1:0]         sqb_reg, sqb_next;
    logic signed [VW-1:0]    sum_acc_reg, sum_acc_next;
    logic                    sum_ovf_reg, sum_ovf_next;
    logic [15:0]             leak_reg, leak_next;
    logic [VW-1:0]           res_value_reg, res_value_next;
    logic                    res_err_reg, res_err_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VW-1:0]           out_value_reg, out_value_next;
    logic                    out_err_reg, out_err_next;

    // shared multiplier operands
    logic [31:0]             mul_a, mul_b;
    logic [63:0]             prod_full;

    // divider step
    logic [32:0]             div_rem_s;
    logic                    div_ge;
    logic [31:0]             div_rem_n;
    logic [DIVD_W-1:0]       div_quo_n;

    // square root step
    logic [SQ_W:0]           sq_sum;
    logic                    sq_ge;

    // decode helpers
    logic                    dec_neg;
    logic [SW-1:0]           dec_absx;
    logic [A_W-1:0]          dec_a;
    logic [A_W-1:0]          dec_n;
    logic                    dec_tanh;
    logic                    fin_tanh;
    logic signed [VW-1:0]    x_ext;
    logic signed [32:0]      sum_t;
    logic [VW-1:0]           sum_sat;
    logic                    sum_of;
    logic [E_W-1:0]          acc_clamped;
    logic [E_W-1:0]          ser_q;
    logic [31:0]             fin_d;
    logic [E_W-1:0]          fin_numer;
    logic [ONE_W-1:0]        fin_q;
    logic [63:0]             relu_rnd;
    logic [63:0]             prod_shr;

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp.value = out_value_reg;
    assign rsp.error_flag = out_err_reg;

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SER_MUL:
            begin
                mul_a = 32'(term_reg);
                mul_b = 32'(f_reg);
            end
            S_POW:
            begin
                mul_a = 32'(e_reg);
                mul_b = 32'(einv_reg);
            end
            S_DRV_MUL:
            begin
                case (func_reg)
                    nau_pkg::FN_RELU:
                    begin
                        mul_a = 32'(absx_reg);
                        mul_b = 32'(leak_reg);
                    end
                    nau_pkg::FN_SQUARE:
                    begin
                        mul_a = 32'(absx_reg);
                        mul_b = 32'(absx_reg);
                    end
                    nau_pkg::FN_SIGMOID_D:
                    begin
                        mul_a = 32'(t_reg);
                        mul_b = 32'(ONE - t_reg);
                    end
                    default:
                    begin
                        mul_a = 32'(t_reg);
                        mul_b = 32'(t_reg);
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = 64'(mul_a) * 64'(mul_b);

    // one restoring division step
    assign div_rem_s = {rem_reg, quo_reg[DIVD_W-1]};
    assign div_ge    = (div_rem_s >= {1'b0, dvs_reg});
    assign div_rem_n = div_ge ? 32'(div_rem_s - {1'b0, dvs_reg}) : div_rem_s[31:0];
    assign div_quo_n = {quo_reg[DIVD_W-2:0], div_ge};

    // one square root step
    assign sq_sum = {1'b0, sqr_reg} + {1'b0, sqb_reg};
    assign sq_ge  = ({1'b0, sqv_reg} >= sq_sum);

    // element decode
    assign dec_neg  = x_reg[SW-1];
    assign dec_absx = dec_neg ? SW'(-x_reg) : SW'(x_reg);
    assign dec_tanh = (func_reg == nau_pkg::FN_TANH) || (func_reg == nau_pkg::FN_TANH_D);
    assign dec_a    = dec_tanh ? {dec_absx, 1'b0} : {1'b0, dec_absx};
    assign dec_n    = dec_a >> FRAC_BITS;
    assign fin_tanh = dec_tanh;
    assign x_ext    = VW'(x_reg);

    // saturating running sum
    assign sum_t   = 33'(sum_acc_reg) + 33'(x_reg);
    assign sum_of  = (sum_t[32] != sum_t[31]);
    assign sum_sat = sum_of ? (sum_t[32] ? VMIN : VMAX) : sum_t[31:0];

    // series bookkeeping
    assign ser_q = quo_reg[E_W-1:0];
    always_comb
    begin
        if (acc_reg[32])
            acc_clamped = '0;
        else if (acc_reg > $signed(33'(QONE)))
            acc_clamped = QONE;
        else
            acc_clamped = acc_reg[E_W-1:0];
    end

    // final sigmoid or tanh division operands
    assign fin_d     = 32'(QONE) + 32'(e_reg);
    assign fin_numer = fin_tanh ? (QONE - e_reg) : (neg_reg ? e_reg : QONE);
    assign fin_q     = quo_reg[ONE_W-1:0];

    assign relu_rnd = (prod_reg + 64'h0000_0000_0000_FFFF) >> 16;
    assign prod_shr = prod_reg >> FRAC_BITS;

    // sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        x_next          = x_reg;
        last_next       = last_reg;
        neg_next        = neg_reg;
        absx_next       = absx_reg;
        a_next          = a_reg;
        f_next          = f_reg;
        term_next       = term_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        einv_next       = einv_reg;
        einv_valid_next = einv_valid_reg;
        einv_mode_next  = einv_mode_reg;
        e_next          = e_reg;
        i_next          = i_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        dvs_next        = dvs_reg;
        cnt_next        = cnt_reg;
        t_next          = t_reg;
        sqv_next        = sqv_reg;
        sqr_next        = sqr_reg;
        sqb_next        = sqb_reg;
        sum_acc_next    = sum_acc_reg;
        sum_ovf_next    = sum_ovf_reg;
        leak_next       = leak_reg;
        res_value_next  = res_value_reg;
        res_err_next    = res_err_reg;
        out_value_next  = out_value_reg;
        out_err_next    = out_err_reg;
        out_valid_next  = out_valid_reg & rsp_stall;

        // configuration write
        if (cfg_valid && cfg_ready)
            leak_next = cfg_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    x_next     = req.sample;
                    last_next  = req.last_element;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                neg_next     = dec_neg;
                absx_next    = dec_absx;
                a_next       = dec_a;
                res_err_next = 1'b0;
                case (func_reg)
                    nau_pkg::FN_SIGMOID, nau_pkg::FN_SIGMOID_D,
                    nau_pkg::FN_TANH, nau_pkg::FN_TANH_D:
                    begin
                        term_next = QONE;
                        acc_next  = 33'(QONE);
                        k_next    = 5'd1;
                        if (dec_n > A_W'(nau_pkg::EXP_MAX_INT))
                        begin
                            e_next     = '0;
                            state_next = S_FIN_LOAD;
                        end
                        else if ((dec_n != '0) && !einv_valid_reg)
                        begin
                            f_next         = QONE;
                            einv_mode_next = 1'b1;
                            state_next     = S_SER_MUL;
                        end
                        else
                        begin
                            f_next         = E_W'(dec_a[FRAC_BITS-1:0]) << (EF - FRAC_BITS);
                            einv_mode_next = 1'b0;
                            state_next     = S_SER_MUL;
                        end
                    end
                    nau_pkg::FN_RELU:
                    begin
                        if (dec_neg)
                            state_next = S_DRV_MUL;
                        else
                        begin
                            res_value_next = (x_ext > $signed(ONE_V)) ? ONE_V : x_ext;
                            state_next     = S_RESULT;
                        end
                    end
                    nau_pkg::FN_RELU_D:
                    begin
                        if (x_ext > $signed(ONE_V))
                            res_value_next = '0;
                        else if (dec_neg)
                            res_value_next = VW'(leak_reg >> (16 - FRAC_BITS));
                        else
                            res_value_next = ONE_V;
                        state_next = S_RESULT;
                    end
                    nau_pkg::FN_SQUARE:
                    begin
                        state_next = S_DRV_MUL;
                    end
                    nau_pkg::FN_SQRT:
                    begin
                        if (dec_neg)
                        begin
                            res_value_next = '0;
                            res_err_next   = 1'b1;
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            sqv_next   = SQ_W'(dec_absx) << FRAC_BITS;
                            sqr_next   = '0;
                            sqb_next   = SQ_W'(1) << (SQ_W - 2);
                            cnt_next   = CNT_W'(SQ_W / 2);
                            state_next = S_SQRT;
                        end
                    end
                    nau_pkg::FN_SUM:
                    begin
                        if (last_reg)
                        begin
                            res_value_next = sum_sat;
                            res_err_next   = sum_ovf_reg | sum_of;
                            sum_acc_next   = '0;
                            sum_ovf_next   = 1'b0;
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            sum_acc_next = sum_sat;
                            sum_ovf_next = sum_ovf_reg | sum_of;
                            state_next   = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // series term: multiply by the argument
            S_SER_MUL:
            begin
                prod_next  = prod_full;
                state_next = S_SER_LOAD;
            end

            // series term: divide by k, top bits only
            S_SER_LOAD:
            begin
                quo_next   = {prod_reg[2*EF:EF], {(DIVD_W-E_W){1'b0}}};
                rem_next   = '0;
                dvs_next   = 32'(k_reg);
                cnt_next   = CNT_W'(E_W);
                state_next = S_SER_DIV;
            end

            S_SER_DIV:
            begin
                quo_next = div_quo_n;
                rem_next = div_rem_n;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_SER_ACC;
            end

            // alternating accumulate
            S_SER_ACC:
            begin
                term_next = ser_q;
                acc_next  = k_reg[0] ? (acc_reg - 33'(ser_q)) : (acc_reg + 33'(ser_q));
                k_next    = k_reg + 1'b1;
                if (k_reg == 5'(nau_pkg::SERIES_TERMS))
                    state_next = S_SER_END;
                else
                    state_next = S_SER_MUL;
            end

            S_SER_END:
            begin
                if (einv_mode_reg)
                begin
                    einv_next       = acc_clamped;
                    einv_valid_next = 1'b1;
                    einv_mode_next  = 1'b0;
                    f_next          = E_W'(a_reg[FRAC_BITS-1:0]) << (EF - FRAC_BITS);
                    term_next       = QONE;
                    acc_next        = 33'(QONE);
                    k_next          = 5'd1;
                    state_next      = S_SER_MUL;
                end
                else
                begin
                    e_next     = acc_clamped;
                    i_next     = I_W'(a_reg >> FRAC_BITS);
                    state_next = S_POW;
                end
            end

            // integer part: repeated multiply by e^-1
            S_POW:
            begin
                if ((i_reg == '0) || (e_reg == '0))
                    state_next = S_FIN_LOAD;
                else
                begin
                    prod_next  = prod_full;
                    state_next = S_POW_UPD;
                end
            end

            S_POW_UPD:
            begin
                e_next     = prod_reg[2*EF:EF];
                i_next     = i_reg - 1'b1;
                state_next = S_POW;
            end

            // rounded quotient for sigmoid or tanh
            S_FIN_LOAD:
            begin
                quo_next   = (DIVD_W'(fin_numer) << FRAC_BITS) + DIVD_W'(fin_d >> 1);
                rem_next   = '0;
                dvs_next   = fin_d;
                cnt_next   = CNT_W'(DIVD_W);
                state_next = S_FIN_DIV;
            end

            S_FIN_DIV:
            begin
                quo_next = div_quo_n;
                rem_next = div_rem_n;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    state_next = S_FIN_RES;
            end

            S_FIN_RES:
            begin
                t_next = fin_q;
                case (func_reg)
                    nau_pkg::FN_SIGMOID:
                    begin
                        res_value_next = VW'(fin_q);
                        state_next     = S_RESULT;
                    end
                    nau_pkg::FN_TANH:
                    begin
                        res_value_next = neg_reg ? (VW'(0) - VW'(fin_q)) : VW'(fin_q);
                        state_next     = S_RESULT;
                    end
                    default:
                    begin
                        state_next = S_DRV_MUL;
                    end
                endcase
            end

            S_DRV_MUL:
            begin
                prod_next  = prod_full;
                state_next = S_DRV_OUT;
            end

            // products for relu, square and the derivatives
            S_DRV_OUT:
            begin
                case (func_reg)
                    nau_pkg::FN_RELU:
                        res_value_next = VW'(0) - relu_rnd[VW-1:0];
                    nau_pkg::FN_SQUARE:
                        res_value_next = (prod_shr > 64'(VMAX)) ? VMAX : prod_shr[VW-1:0];
                    nau_pkg::FN_SIGMOID_D:
                        res_value_next = prod_shr[VW-1:0];
                    default:
                        res_value_next = ONE_V - prod_shr[VW-1:0];
                endcase
                state_next = S_RESULT;
            end

            // bit-pair square root, root taken from the last step
            S_SQRT:
            begin
                if (sq_ge)
                begin
                    sqv_next = SQ_W'({1'b0, sqv_reg} - sq_sum);
                    sqr_next = (sqr_reg >> 1) + sqb_reg;
                end
                else
                    sqr_next = sqr_reg >> 1;
                sqb_next = sqb_reg >> 2;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    res_value_next = VW'(sqr_next);
                    state_next     = S_RESULT;
                end
            end

            // hand result to the output register
            S_RESULT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_value_next = res_value_reg;
                    out_err_next   = res_err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            einv_valid_reg <= 1'b0;
            einv_mode_reg  <= 1'b0;
            sum_acc_reg    <= '0;
            sum_ovf_reg    <= 1'b0;
            leak_reg       <= nau_pkg::LEAK_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            einv_valid_reg <= einv_valid_next;
            einv_mode_reg  <= einv_mode_next;
            sum_acc_reg    <= sum_acc_next;
            sum_ovf_reg    <= sum_ovf_next;
            leak_reg       <= leak_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        x_reg         <= x_next;
        last_reg      <= last_next;
        neg_reg       <= neg_next;
        absx_reg      <= absx_next;
        a_reg         <= a_next;
        f_reg         <= f_next;
        term_reg      <= term_next;
        acc_reg       <= acc_next;
        k_reg         <= k_next;
        einv_reg      <= einv_next;
        e_reg         <= e_next;
        i_reg         <= i_next;
        prod_reg      <= prod_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        cnt_reg       <= cnt_next;
        t_reg         <= t_next;
        sqv_reg       <= sqv_next;
        sqr_reg       <= sqr_next;
        sqb_reg       <= sqb_next;
        res_value_reg <= res_value_next;
        res_err_reg   <= res_err_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

endmodule

`default_nettype wire

// ===== test/nau_checker.sv =====
// scoreboard for the activation unit: watches the req, rsp and cfg channels,
// predicts every rsp transaction and compares it field by field
// depends on nau_pkg for the channel structs, function codes and constants
`timescale 1ns / 1ps
`default_nettype none

module nau_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_stall,
    input  wire nau_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_stall,
    input  wire nau_pkg::rsp_t rsp,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire logic [15:0]   cfg_data,
    output int                 failures,
    output int                 outstanding
);

    localparam int FRAC = 12;
    localparam longint unsigned Q_ONE = 64'd1 << nau_pkg::EXP_FRAC;
    localparam longint ONE = 64'sd1 << FRAC;

    nau_pkg::rsp_t expected_rsp[$];
    logic [15:0]   leak_slope;
    longint        running_sum;
    bit            sum_saturated;

    // e^-f for f in Q30 within [0, 1], result in Q30
    function automatic longint unsigned exp_frac(longint unsigned f);
        longint          acc;
        longint unsigned term;
        acc  = longint'(Q_ONE);
        term = Q_ONE;
        for (int k = 1; k <= nau_pkg::SERIES_TERMS; k++)
        begin
            term = ((term * f) >> nau_pkg::EXP_FRAC) / longint'(k);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > longint'(Q_ONE))
            acc = longint'(Q_ONE);
        return longint'(acc);
    endfunction

    // e^-a for a >= 0 with FRAC fraction bits, result in Q30
    function automatic longint unsigned exp_neg(longint unsigned a);
        longint unsigned whole, f, e, einv;
        whole = a >> FRAC;
        f     = (a & ((64'd1 << FRAC) - 1)) << (nau_pkg::EXP_FRAC - FRAC);
        if (whole > nau_pkg::EXP_MAX_INT)
            return 0;
        e    = exp_frac(f);
        einv = exp_frac(Q_ONE);
        for (longint unsigned i = 0; i < whole && e != 0; i++)
            e = (e * einv) >> nau_pkg::EXP_FRAC;
        return e;
    endfunction

    function automatic longint sigmoid_q(longint x);
        longint unsigned mag, e, d, num;
        mag = (x < 0) ? -x : x;
        e   = exp_neg(mag);
        d   = Q_ONE + e;
        num = ((x < 0) ? e : Q_ONE) << FRAC;
        return longint'((num + d / 2) / d);
    endfunction

    function automatic longint tanh_q(longint x);
        longint unsigned mag, e, d, num;
        longint t;
        mag = (x < 0) ? -x : x;
        e   = exp_neg(2 * mag);
        d   = Q_ONE + e;
        num = (Q_ONE - e) << FRAC;
        t   = longint'((num + d / 2) / d);
        return (x < 0) ? -t : t;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, b;
        root = 0;
        b    = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v    = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // expected outcome of one element; sum state is updated here
    task automatic activation_result(input nau_pkg::req_t item);
        longint x, v, t;
        longint unsigned mag;
        bit err, emits;
        nau_pkg::rsp_t r;
        x     = longint'(item.sample);
        v     = 0;
        err   = 1'b0;
        emits = 1'b1;
        case (item.func)
            nau_pkg::FN_SIGMOID:   v = sigmoid_q(x);
            nau_pkg::FN_SIGMOID_D:
            begin
                t = sigmoid_q(x);
                v = (t * (ONE - t)) >>> FRAC;
            end
            nau_pkg::FN_TANH:      v = tanh_q(x);
            nau_pkg::FN_TANH_D:
            begin
                t = tanh_q(x);
                v = ONE - ((t * t) >>> FRAC);
            end
            nau_pkg::FN_RELU:
                if (x > ONE)
                    v = ONE;
                else if (x < 0)
                begin
                    mag = longint'(-x) * leak_slope;
                    v   = -longint'((mag + 64'hFFFF) >> 16);
                end
                else
                    v = x;
            nau_pkg::FN_RELU_D:
                if (x > ONE)
                    v = 0;
                else if (x < 0)
                    v = longint'(leak_slope >> (16 - FRAC));
                else
                    v = ONE;
            nau_pkg::FN_SQUARE:
            begin
                v = (x * x) >>> FRAC;
                if (v > 64'sd2147483647)
                    v = 64'sd2147483647;
            end
            nau_pkg::FN_SQRT:
                if (x < 0)
                    err = 1'b1;
                else
                    v = longint'(int_sqrt(longint'(x) << FRAC));
            nau_pkg::FN_SUM:
            begin
                t = running_sum + x;
                if (t > 64'sd2147483647)
                begin
                    t = 64'sd2147483647;
                    sum_saturated = 1'b1;
                end
                if (t < -64'sd2147483648)
                begin
                    t = -64'sd2147483648;
                    sum_saturated = 1'b1;
                end
                running_sum = t;
                if (item.last_element)
                begin
                    v   = running_sum;
                    err = sum_saturated;
                    running_sum   = 0;
                    sum_saturated = 1'b0;
                end
                else
                    emits = 1'b0;
            end
            default:      emits = 1'b0;
        endcase
        if (emits)
        begin
            r.value      = v[31:0];
            r.error_flag = err;
            expected_rsp.push_back(r);
        end
    endtask

    // compare each rsp transaction, then predict from each req transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leak_slope    <= nau_pkg::LEAK_RESET;
            running_sum    = 0;
            sum_saturated  = 1'b0;
            failures      <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%t: unexpected rsp value=%0d err=%0b", $time,
                             rsp.value, rsp.error_flag);
                    failures <= failures + 1;
                end
                else
                begin
                    if (rsp !== expected_rsp[0])
                    begin
                        $display({"%t: rsp mismatch expected value=%0d err=%0b,",
                                  " got value=%0d err=%0b"},
                                 $time, expected_rsp[0].value, expected_rsp[0].error_flag,
                                 rsp.value, rsp.error_flag);
                        failures <= failures + 1;
                    end
                    void'(expected_rsp.pop_front());
                end
            end
            if (req_valid && !req_stall)
                activation_result(req);
            if (cfg_valid && cfg_ready)
                leak_slope <= cfg_data;
        end
    end

    assign outstanding = expected_rsp.size();

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// stimulus and verdict for neural_activation_unit: directed elements, short
// sums, random phases under several leak slopes with stalls
// depends on nau_pkg, neural_activation_unit and nau_checker
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam int PHASE_ITEMS = 160;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    nau_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    nau_pkg::rsp_t rsp;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [15:0]   cfg_data;
    int            failures;
    int            outstanding;
    logic          steady;
    logic          hold_go;
    int            hold_left;

    neural_activation_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    nau_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off
    initial
    begin
        rsp_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_go && hold_left == 0)
                hold_left = 3000;
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left = hold_left - 1;
            end
            else
                rsp_stall <= !steady && ($urandom_range(99) < 19);
        end
    end

    // one req transaction, with random idle cycles ahead of it
    task automatic send(input logic [3:0] fn, input logic signed [15:0] s,
                        input logic last);
        nau_pkg::req_t item;
        item.func         = fn;
        item.sample       = s;
        item.last_element = last;
        while (!steady && $urandom_range(99) < 19)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // wait until the block is idle and every expected transaction has arrived
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || req_stall || rsp_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_leak(input logic [15:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return $signed(16'($urandom_range(32768))) - 16'sd16384;
            2: return $urandom_range(1) ? 16'(16'sh7FFF - $urandom_range(3))
                                         : 16'(16'sh8000 + $urandom_range(3));
            default: return $signed(16'($urandom_range(16))) - 16'sd8;
        endcase
    endfunction

    initial
    begin
        logic [15:0] leak_set[5];
        int r, n;
        leak_set = '{16'd655, 16'd0, 16'd65535, 16'd1234, 16'd40000};
        leak_set[3] = 16'($urandom_range(65535));
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        steady    = 1'b0;
        hold_go   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 5; p++)
        begin
            write_leak(leak_set[p]);
            if (p == 0)
            begin
                // directed: extremes, every code, the special cases
                send(nau_pkg::FN_SIGMOID, 16'sd0, 1'b0);
                send(nau_pkg::FN_SIGMOID, 16'sh7FFF, 1'b1);
                send(nau_pkg::FN_SIGMOID, 16'sh8000, 1'b0);
                send(nau_pkg::FN_SIGMOID, -16'sd4096, 1'b0);
                send(nau_pkg::FN_SIGMOID_D, 16'sd0, 1'b0);
                send(nau_pkg::FN_SIGMOID_D, 16'sh8000, 1'b0);
                send(nau_pkg::FN_TANH, 16'sh7FFF, 1'b0);
                send(nau_pkg::FN_TANH, -16'sd1, 1'b0);
                send(nau_pkg::FN_TANH_D, 16'sd2048, 1'b0);
                send(nau_pkg::FN_TANH_D, 16'sh8000, 1'b0);
                send(nau_pkg::FN_RELU, 16'sh7FFF, 1'b0);
                send(nau_pkg::FN_RELU, 16'sh8000, 1'b1);
                send(nau_pkg::FN_RELU, 16'sd4096, 1'b0);
                send(nau_pkg::FN_RELU, 16'sd4097, 1'b0);
                send(nau_pkg::FN_RELU, -16'sd1, 1'b0);
                send(nau_pkg::FN_RELU_D, 16'sd4097, 1'b0);
                send(nau_pkg::FN_RELU_D, -16'sd1, 1'b0);
                send(nau_pkg::FN_RELU_D, 16'sd0, 1'b0);
                send(nau_pkg::FN_SQUARE, 16'sh8000, 1'b0);
                send(nau_pkg::FN_SQRT, 16'sh7FFF, 1'b0);
                send(nau_pkg::FN_SQRT, -16'sd1, 1'b0);
                send(nau_pkg::FN_SQRT, 16'sd0, 1'b1);
                send(nau_pkg::FN_SUM, 16'sh7FFF, 1'b0);
                send(nau_pkg::FN_SUM, 16'sh8000, 1'b1);
                send(4'd9, 16'sd100, 1'b1);
                send(4'd15, 16'sh8000, 1'b0);
            end
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if (p == 2)
                    steady <= (n < 60);
                if (p == 1 && n == 40)
                    hold_go <= 1'b1;
                else
                    hold_go <= 1'b0;
                r = $urandom_range(99);
                if (r < 28)
                begin
                    send(4'($urandom_range(3)), pick_sample(), 1'($urandom_range(1)));
                    n++;
                end
                else if (r < 80)
                begin
                    send(4'($urandom_range(7, 4)), pick_sample(), 1'($urandom_range(1)));
                    n++;
                end
                else if (r < 96)
                begin
                    for (int k = $urandom_range(5); k > 0; k--)
                    begin
                        send(nau_pkg::FN_SUM, pick_sample(), 1'b0);
                        n++;
                    end
                    send(nau_pkg::FN_SUM, pick_sample(), 1'b1);
                    n++;
                end
                else
                    send(4'($urandom_range(15, 9)), pick_sample(), 1'($urandom_range(1)));
            end
            steady  <= 1'b0;
            hold_go <= 1'b0;
            drain();
        end

        if (failures == 0)
            $display("** neural_activation_unit: PASSED **");
        else
            $display("** neural_activation_unit: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #200_000_000;
        $display("** neural_activation_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== neural_activation_unit.f =====
rtl/nau_pkg.sv
rtl/neural_activation_unit.sv
test/nau_checker.sv
test/testbench.sv
